FILE: rtl/smpg_pkg.sv
`timescale 1ns / 1ps

package smpg_pkg;

  localparam int SINE_POINTS_DEF = 256;
  localparam int CfgAddrW = 5;

  // zero point of the sine table and the full-scale compare value
  localparam logic [11:0] SINE_MID = 12'd1600;
  localparam logic [10:0] FULL_CUR = 11'd1599;
  localparam logic [6:0]  PCT_MAX  = 7'd100;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_LOCK  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_SPEED_DIVIDER  = 3'd0,
    REG_STEP_RATE      = 3'd1,
    REG_AMPLITUDE      = 3'd2,
    REG_HALF_STEP_MODE = 3'd3,
    REG_PHASE_LEAD     = 3'd4,
    REG_REVERSE        = 3'd5,
    REG_STOP_AT_TARGET = 3'd6,
    REG_TARGET_STEPS   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] hold_duty;
  } in_t;

  typedef struct packed {
    logic               drive_valid;
    logic [10:0]        current_a;
    logic [10:0]        current_b;
    logic               polarity_a;
    logic               polarity_b;
    logic               running;
    logic signed [31:0] position;
    logic               target_reached;
  } out_t;

  typedef struct packed {
    logic [15:0] speed_divider;
    logic [8:0]  step_rate;
    logic [6:0]  amplitude;
    logic        half_step_mode;
    logic [6:0]  phase_lead;
    logic        reverse;
    logic        stop_at_target;
    logic [31:0] target_steps;
  } cfg_t;

  // one drive request as it travels down the pipeline
  typedef struct packed {
    logic        dv;
    logic        sine;     // 1 sine lookup, 0 half-step pattern
    logic [6:0]  pct;
    logic [3:0]  pat;      // polarity a, enable a, polarity b, enable b
    logic        running;
    logic        reached;
    logic [31:0] position;
  } drive_t;

  localparam logic [3:0] HALF_TAB [8] = '{
    4'hF, 4'hC, 4'hA, 4'h1, 4'h5, 4'h6, 4'h7, 4'hB
  };

  localparam logic [11:0] SINE_TAB [256] = '{
    12'd1600, 12'd1639, 12'd1678, 12'd1718, 12'd1757, 12'd1796, 12'd1835, 12'd1873,
    12'd1912, 12'd1950, 12'd1989, 12'd2026, 12'd2064, 12'd2102, 12'd2139, 12'd2175,
    12'd2212, 12'd2248, 12'd2284, 12'd2319, 12'd2354, 12'd2388, 12'd2422, 12'd2455,
    12'd2488, 12'd2521, 12'd2553, 12'd2584, 12'd2614, 12'd2644, 12'd2674, 12'd2703,
    12'd2731, 12'd2758, 12'd2785, 12'd2811, 12'd2836, 12'd2861, 12'd2884, 12'd2907,
    12'd2930, 12'd2951, 12'd2972, 12'd2991, 12'd3010, 12'd3028, 12'd3045, 12'd3062,
    12'd3077, 12'd3092, 12'd3106, 12'd3118, 12'd3130, 12'd3141, 12'd3151, 12'd3160,
    12'd3168, 12'd3175, 12'd3182, 12'd3187, 12'd3191, 12'd3195, 12'd3197, 12'd3199,
    12'd3199, 12'd3199, 12'd3197, 12'd3195, 12'd3191, 12'd3187, 12'd3182, 12'd3175,
    12'd3168, 12'd3160, 12'd3151, 12'd3141, 12'd3130, 12'd3118, 12'd3106, 12'd3092,
    12'd3077, 12'd3062, 12'd3045, 12'd3028, 12'd3010, 12'd2991, 12'd2972, 12'd2951,
    12'd2930, 12'd2907, 12'd2884, 12'd2861, 12'd2836, 12'd2811, 12'd2785, 12'd2758,
    12'd2731, 12'd2703, 12'd2674, 12'd2644, 12'd2614, 12'd2584, 12'd2553, 12'd2521,
    12'd2488, 12'd2455, 12'd2422, 12'd2388, 12'd2354, 12'd2319, 12'd2284, 12'd2248,
    12'd2212, 12'd2175, 12'd2139, 12'd2102, 12'd2064, 12'd2026, 12'd1989, 12'd1950,
    12'd1912, 12'd1873, 12'd1835, 12'd1796, 12'd1757, 12'd1718, 12'd1678, 12'd1639,
    12'd1600, 12'd1561, 12'd1522, 12'd1482, 12'd1443, 12'd1404, 12'd1365, 12'd1327,
    12'd1288, 12'd1250, 12'd1211, 12'd1174, 12'd1136, 12'd1098, 12'd1061, 12'd1025,
    12'd988,  12'd952,  12'd916,  12'd881,  12'd846,  12'd812,  12'd778,  12'd745,
    12'd712,  12'd679,  12'd647,  12'd616,  12'd586,  12'd556,  12'd526,  12'd497,
    12'd469,  12'd442,  12'd415,  12'd389,  12'd364,  12'd339,  12'd316,  12'd293,
    12'd270,  12'd249,  12'd228,  12'd209,  12'd190,  12'd172,  12'd155,  12'd138,
    12'd123,  12'd108,  12'd94,   12'd82,   12'd70,   12'd59,   12'd49,   12'd40,
    12'd32,   12'd25,   12'd18,   12'd13,   12'd9,    12'd5,    12'd3,    12'd1,
    12'd1,    12'd1,    12'd3,    12'd5,    12'd9,    12'd13,   12'd18,   12'd25,
    12'd32,   12'd40,   12'd49,   12'd59,   12'd70,   12'd82,   12'd94,   12'd108,
    12'd123,  12'd138,  12'd155,  12'd172,  12'd190,  12'd209,  12'd228,  12'd249,
    12'd270,  12'd293,  12'd316,  12'd339,  12'd364,  12'd389,  12'd415,  12'd442,
    12'd469,  12'd497,  12'd526,  12'd556,  12'd586,  12'd616,  12'd647,  12'd679,
    12'd712,  12'd745,  12'd778,  12'd812,  12'd846,  12'd881,  12'd916,  12'd952,
    12'd988,  12'd1025, 12'd1061, 12'd1098, 12'd1136, 12'd1174, 12'd1211, 12'd1250,
    12'd1288, 12'd1327, 12'd1365, 12'd1404, 12'd1443, 12'd1482, 12'd1522, 12'd1561
  };

endpackage

FILE: rtl/smpg_regs.sv
`timescale 1ns / 1ps

module smpg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [smpg_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           half_clr_i,
  output smpg_pkg::cfg_t                 cfg_o
);
  import smpg_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e sel;
  logic     wr;

  assign pready = 1'b1;
  assign sel    = reg_idx_e'(paddr[CfgAddrW-1:2]);
  assign wr     = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_divider  <= 16'd6;
      cfg_q.step_rate      <= 9'd64;
      cfg_q.amplitude      <= 7'd60;
      cfg_q.half_step_mode <= 1'b0;
      cfg_q.phase_lead     <= 7'd0;
      cfg_q.reverse        <= 1'b0;
      cfg_q.stop_at_target <= 1'b0;
      cfg_q.target_steps   <= 32'd0;
    end else if (wr) begin
      case (sel)
        REG_SPEED_DIVIDER:  cfg_q.speed_divider  <= pwdata[15:0];
        REG_STEP_RATE:      cfg_q.step_rate      <= pwdata[8:0];
        REG_AMPLITUDE:      cfg_q.amplitude      <= pwdata[6:0];
        REG_HALF_STEP_MODE: cfg_q.half_step_mode <= pwdata[0];
        REG_PHASE_LEAD:     cfg_q.phase_lead     <= pwdata[6:0];
        REG_REVERSE:        cfg_q.reverse        <= pwdata[0];
        REG_STOP_AT_TARGET: cfg_q.stop_at_target <= pwdata[0];
        REG_TARGET_STEPS:   cfg_q.target_steps   <= pwdata;
        default: ;
      endcase
    end else if (half_clr_i) begin
      // a stop command falls back to microstep mode
      cfg_q.half_step_mode <= 1'b0;
    end
  end

  always_comb begin
    case (sel)
      REG_SPEED_DIVIDER:  prdata = {16'd0, cfg_q.speed_divider};
      REG_STEP_RATE:      prdata = {23'd0, cfg_q.step_rate};
      REG_AMPLITUDE:      prdata = {25'd0, cfg_q.amplitude};
      REG_HALF_STEP_MODE: prdata = {31'd0, cfg_q.half_step_mode};
      REG_PHASE_LEAD:     prdata = {25'd0, cfg_q.phase_lead};
      REG_REVERSE:        prdata = {31'd0, cfg_q.reverse};
      REG_STOP_AT_TARGET: prdata = {31'd0, cfg_q.stop_at_target};
      REG_TARGET_STEPS:   prdata = cfg_q.target_steps;
      default:            prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/smpg_ctrl.sv
`timescale 1ns / 1ps

module smpg_ctrl #(
  parameter int SINE_POINTS = smpg_pkg::SINE_POINTS_DEF,
  localparam int IdxW = $clog2(SINE_POINTS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  smpg_pkg::in_t    in_data_i,
  input  smpg_pkg::cfg_t   cfg_i,
  output logic             half_clr_o,
  output logic             dn_valid_o,
  input  logic             dn_ready_i,
  output smpg_pkg::drive_t dn_drive_o,
  output logic [IdxW-1:0]  dn_idx_o
);
  import smpg_pkg::*;

  localparam logic [IdxW:0] SpE = (IdxW+1)'(SINE_POINTS);

  function automatic logic [6:0] sat_pct(input logic [6:0] p);
    sat_pct = (p > PCT_MAX) ? PCT_MAX : p;
  endfunction

  logic            en_q, en_d;
  logic [15:0]     tick_q, tick_d, tick_inc;
  logic [5:0]      frac_q, frac_d;
  logic [IdxW-1:0] idx_q, idx_d, idx_out;
  logic [2:0]      half_q, half_d, half_step;
  logic [31:0]     evt_q, evt_d, evt_inc;
  logic [31:0]     pos_q, pos_d;
  logic [9:0]      acc_sum;
  logic [3:0]      moves;
  logic [IdxW:0]   m_ext, idx_fwd, idx_rev;
  logic [6:0]      amp;
  logic            accept, rdy, v_q;
  drive_t          drv, drv_q;
  logic [IdxW-1:0] idx_s_q;

  assign rdy        = !v_q || dn_ready_i;
  assign in_stall_o = !rdy;
  assign accept     = in_valid_i && rdy;
  assign half_clr_o = accept && (cmd_e'(in_data_i.cmd) == CMD_STOP);

  assign tick_inc  = tick_q + 16'd1;
  assign evt_inc   = evt_q + 32'd1;
  assign acc_sum   = {4'd0, frac_q} + {1'b0, cfg_i.step_rate};
  assign moves     = acc_sum[9:6];
  assign amp       = sat_pct(cfg_i.amplitude);
  // at most eight moves, below the table size for tables of more than eight points
  assign m_ext     = (IdxW+1)'(moves);
  assign half_step = cfg_i.reverse ? half_q - moves[2:0] : half_q + moves[2:0];

  always_comb begin
    idx_fwd = {1'b0, idx_q} + m_ext;
    if (idx_fwd >= SpE) idx_fwd = idx_fwd - SpE;
    if ({1'b0, idx_q} >= m_ext) begin
      idx_rev = {1'b0, idx_q} - m_ext;
    end else begin
      idx_rev = {1'b0, idx_q} + SpE - m_ext;
    end
  end

  always_comb begin
    en_d    = en_q;
    tick_d  = tick_q;
    frac_d  = frac_q;
    idx_d   = idx_q;
    half_d  = half_q;
    evt_d   = evt_q;
    pos_d   = pos_q;
    idx_out = idx_q;
    drv     = '0;
    case (cmd_e'(in_data_i.cmd))
      CMD_START: begin
        idx_d  = '0;
        tick_d = 16'd0;
        frac_d = 6'd0;
        evt_d  = 32'd0;
        en_d   = 1'b1;
      end
      CMD_STOP: begin
        en_d   = 1'b0;
        drv.dv = 1'b1;
      end
      CMD_LOCK: begin
        en_d     = 1'b0;
        drv.dv   = 1'b1;
        drv.sine = 1'b1;
        drv.pct  = sat_pct(in_data_i.hold_duty);
      end
      CMD_TICK: begin
        if (en_q) begin
          if (tick_inc < cfg_i.speed_divider) begin
            tick_d = tick_inc;
            if (!cfg_i.half_step_mode) begin
              drv.dv   = 1'b1;
              drv.sine = 1'b1;
              drv.pct  = amp;
            end
          end else begin
            tick_d = 16'd0;
            frac_d = acc_sum[5:0];
            drv.dv  = 1'b1;
            drv.pct = amp;
            if (cfg_i.half_step_mode) begin
              half_d  = half_step;
              drv.pat = HALF_TAB[half_step];
            end else begin
              idx_d    = cfg_i.reverse ? idx_rev[IdxW-1:0] : idx_fwd[IdxW-1:0];
              idx_out  = idx_d;
              drv.sine = 1'b1;
            end
            evt_d = evt_inc;
            pos_d = cfg_i.reverse ? pos_q - 32'd1 : pos_q + 32'd1;
            if (cfg_i.stop_at_target && (cfg_i.target_steps != 32'd0) &&
                (evt_inc >= cfg_i.target_steps)) begin
              // keep the step polarities, drop the current
              en_d        = 1'b0;
              drv.pct     = 7'd0;
              drv.reached = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    drv.running  = en_d;
    drv.position = pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b0;
      tick_q <= 16'd0;
      frac_q <= 6'd0;
      idx_q  <= '0;
      half_q <= 3'd0;
      evt_q  <= 32'd0;
      pos_q  <= 32'd0;
      v_q    <= 1'b0;
    end else begin
      if (rdy) v_q <= in_valid_i;
      if (accept) begin
        en_q   <= en_d;
        tick_q <= tick_d;
        frac_q <= frac_d;
        idx_q  <= idx_d;
        half_q <= half_d;
        evt_q  <= evt_d;
        pos_q  <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      drv_q   <= drv;
      idx_s_q <= idx_out;
    end
  end

  assign dn_valid_o = v_q;
  assign dn_drive_o = drv_q;
  assign dn_idx_o   = idx_s_q;

endmodule

FILE: rtl/smpg_phase.sv
`timescale 1ns / 1ps

module smpg_phase #(
  parameter int SINE_POINTS = smpg_pkg::SINE_POINTS_DEF,
  localparam int IdxW = $clog2(SINE_POINTS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [6:0]       lead_i,
  input  logic             up_valid_i,
  output logic             up_ready_o,
  input  smpg_pkg::drive_t up_drive_i,
  input  logic [IdxW-1:0]  up_idx_i,
  output logic             dn_valid_o,
  input  logic             dn_ready_i,
  output smpg_pkg::drive_t dn_drive_o,
  output logic [7:0]       dn_ta_o,
  output logic [7:0]       dn_tb_o
);
  import smpg_pkg::*;

  localparam int SumW = IdxW + 2;
  localparam logic [SumW-1:0] SpS  = SumW'(SINE_POINTS);
  localparam logic [SumW-1:0] Sp2S = SumW'(2 * SINE_POINTS);
  localparam logic [SumW-1:0] QrtS = SumW'(SINE_POINTS / 4);
  // index * 256 / SINE_POINTS as a multiply by a rounded-up reciprocal
  localparam int MapShift = 28;
  localparam int MapKW = 31;
  localparam logic [MapKW-1:0] MapK =
    MapKW'(((64'd1 << (MapShift + 8)) + 64'(SINE_POINTS) - 64'd1) / 64'(SINE_POINTS));
  localparam int ProdW = IdxW + MapKW;

  logic            v2_q, v3_q, rdy2, rdy3;
  drive_t          drv2_q, drv3_q;
  logic [SumW-1:0] sa, sb;
  logic [IdxW-1:0] ia, ib, ia_q, ib_q;
  logic [ProdW-1:0] pa, pb;
  logic [7:0]      ta_q, tb_q;

  assign rdy3       = !v3_q || dn_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign up_ready_o = rdy2;

  // lead can reach past two table turns only for the smallest sizes
  always_comb begin
    sa = SumW'(up_idx_i) + SumW'(lead_i);
    if (sa >= Sp2S) begin
      sa = sa - Sp2S;
    end else if (sa >= SpS) begin
      sa = sa - SpS;
    end
    ia = sa[IdxW-1:0];
    sb = SumW'(ia) + QrtS;
    if (sb >= SpS) sb = sb - SpS;
    ib = sb[IdxW-1:0];
  end

  assign pa = ProdW'(ia_q) * ProdW'(MapK);
  assign pb = ProdW'(ib_q) * ProdW'(MapK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy2) v2_q <= up_valid_i;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && up_valid_i) begin
      drv2_q <= up_drive_i;
      ia_q   <= ia;
      ib_q   <= ib;
    end
    if (rdy3 && v2_q) begin
      drv3_q <= drv2_q;
      ta_q   <= pa[MapShift+7:MapShift];
      tb_q   <= pb[MapShift+7:MapShift];
    end
  end

  assign dn_valid_o = v3_q;
  assign dn_drive_o = drv3_q;
  assign dn_ta_o    = ta_q;
  assign dn_tb_o    = tb_q;

endmodule

FILE: rtl/smpg_current.sv
`timescale 1ns / 1ps

module smpg_current (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             up_valid_i,
  output logic             up_ready_o,
  input  smpg_pkg::drive_t up_drive_i,
  input  logic [7:0]       up_ta_i,
  input  logic [7:0]       up_tb_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output smpg_pkg::out_t   out_data_o
);
  import smpg_pkg::*;

  // x / 100 for x below 2^18 as (x * ceil(2^25 / 100)) >> 25
  localparam int DivShift = 25;
  localparam logic [18:0] DivK = 19'd335545;

  logic        v4_q, v5_q, rdy4, rdy5;
  drive_t      drv4_q;
  logic [11:0] va, vb;
  logic [10:0] mag_a, mag_b;
  logic        pol_a, pol_b, pol_a_q, pol_b_q;
  logic [17:0] prod_a_q, prod_b_q;
  logic [36:0] qa, qb;
  out_t        out_q;

  assign rdy5       = !v5_q || !out_stall_i;
  assign rdy4       = !v4_q || rdy5;
  assign up_ready_o = rdy4;

  assign va = SINE_TAB[up_ta_i];
  assign vb = SINE_TAB[up_tb_i];

  always_comb begin
    if (up_drive_i.sine) begin
      pol_a = va >= SINE_MID;
      pol_b = vb >= SINE_MID;
      mag_a = pol_a ? 11'(va - SINE_MID) : 11'(SINE_MID - va);
      mag_b = pol_b ? 11'(vb - SINE_MID) : 11'(SINE_MID - vb);
    end else begin
      pol_a = up_drive_i.pat[3];
      pol_b = up_drive_i.pat[1];
      mag_a = up_drive_i.pat[2] ? FULL_CUR : 11'd0;
      mag_b = up_drive_i.pat[0] ? FULL_CUR : 11'd0;
    end
  end

  assign qa = 37'(prod_a_q) * 37'(DivK);
  assign qb = 37'(prod_b_q) * 37'(DivK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy4) v4_q <= up_valid_i;
      if (rdy5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && up_valid_i) begin
      drv4_q   <= up_drive_i;
      pol_a_q  <= pol_a;
      pol_b_q  <= pol_b;
      prod_a_q <= 18'(mag_a) * 18'(up_drive_i.pct);
      prod_b_q <= 18'(mag_b) * 18'(up_drive_i.pct);
    end
    if (rdy5 && v4_q) begin
      out_q.drive_valid    <= drv4_q.dv;
      out_q.current_a      <= qa[DivShift+10:DivShift];
      out_q.current_b      <= qb[DivShift+10:DivShift];
      out_q.polarity_a     <= pol_a_q;
      out_q.polarity_b     <= pol_b_q;
      out_q.running        <= drv4_q.running;
      out_q.position       <= drv4_q.position;
      out_q.target_reached <= drv4_q.reached;
    end
  end

  assign out_valid_o = v5_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/stepper_microstep_phase_generator_core.sv
`timescale 1ns / 1ps

// Two-phase stepper drive generator: each input transaction carries one command (tick, start,
// stop, lock) and yields exactly one result transaction with the phase A/B PWM compare values,
// polarities, run state and signed step position. One command is taken every clock cycle unless
// the result side stalls; it passes through command decode and state update, table index wrap,
// index scaling multiply, table lookup with current multiply, and the divide-by-100 reciprocal
// multiply, each registered. Stalls on the result side back up through the pipeline, and a bubble
// anywhere in it still lets a new command in. Registers are written over the APB port at byte
// address 4*index; the user must write them only while no command is in flight, the block does not check it.
module stepper_microstep_phase_generator_core #(
  parameter int SINE_POINTS = smpg_pkg::SINE_POINTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  smpg_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output smpg_pkg::out_t                out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [smpg_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import smpg_pkg::*;

  localparam int IdxW = $clog2(SINE_POINTS);

  cfg_t            cfg;
  logic            half_clr;
  logic            c_valid, c_ready, p_valid, p_ready;
  drive_t          c_drive, p_drive;
  logic [IdxW-1:0] c_idx;
  logic [7:0]      p_ta, p_tb;

  smpg_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .half_clr_i (half_clr),
    .cfg_o      (cfg)
  );

  smpg_ctrl #(.SINE_POINTS(SINE_POINTS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .half_clr_o (half_clr),
    .dn_valid_o (c_valid),
    .dn_ready_i (c_ready),
    .dn_drive_o (c_drive),
    .dn_idx_o   (c_idx)
  );

  smpg_phase #(.SINE_POINTS(SINE_POINTS)) u_phase (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .lead_i     (cfg.phase_lead),
    .up_valid_i (c_valid),
    .up_ready_o (c_ready),
    .up_drive_i (c_drive),
    .up_idx_i   (c_idx),
    .dn_valid_o (p_valid),
    .dn_ready_i (p_ready),
    .dn_drive_o (p_drive),
    .dn_ta_o    (p_ta),
    .dn_tb_o    (p_tb)
  );

  smpg_current u_current (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .up_valid_i  (p_valid),
    .up_ready_o  (p_ready),
    .up_drive_i  (p_drive),
    .up_ta_i     (p_ta),
    .up_tb_i     (p_tb),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/smpg_checker.sv
`timescale 1ns / 1ps

module smpg_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           out_valid_o,
  input  logic           out_stall_i,
  input  smpg_pkg::out_t out_data_o
);
  import smpg_pkg::*;

  // a result waiting on the sink holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // no drive means zero currents and polarities
  a_no_drive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.drive_valid |->
      out_data_o.current_a == 11'd0 && out_data_o.current_b == 11'd0 &&
      !out_data_o.polarity_a && !out_data_o.polarity_b)
    else $error("undriven result carries current or polarity");

  // reaching the target stops the drive with zero current
  a_target_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.target_reached |->
      out_data_o.drive_valid && !out_data_o.running &&
      out_data_o.current_a == 11'd0 && out_data_o.current_b == 11'd0)
    else $error("target reached without a clean stop");

  // compare values stay within the pwm period
  a_cur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.current_a <= FULL_CUR && out_data_o.current_b <= FULL_CUR)
    else $error("current above full scale");

endmodule

bind stepper_microstep_phase_generator_core smpg_checker u_smpg_checker (.*);

FILE: tb/stepper_microstep_phase_generator_core_tb.sv
`timescale 1ns / 1ps

module stepper_microstep_phase_generator_core_tb;
  import smpg_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldoffCycles = 250;
  localparam real Pi = 3.14159265358979323846;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // register copies
  logic [15:0] cfg_divider;
  logic [8:0] cfg_rate;
  logic [6:0] cfg_amp;
  logic cfg_half;
  logic [6:0] cfg_lead;
  logic cfg_reverse;
  logic cfg_stop_tgt;
  logic [31:0] cfg_target;

  // drive state as the predictor sees it
  logic mdl_run;
  logic [15:0] mdl_ticks;
  logic [5:0] mdl_frac;
  logic [7:0] mdl_index;
  logic [2:0] mdl_half_phase;
  logic [31:0] mdl_events;
  logic [31:0] mdl_position;

  int unsigned sine_lut [256];
  out_t pending_drives [$];
  int drive_errors = 0;
  int src_idle_pct = 0;
  int rcv_stall_pct = 0;
  logic stall_hold = 1'b0;
  int unsigned cycle_count = 0;

  stepper_microstep_phase_generator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned clip_pct(input logic [6:0] pct);
    return (pct > 7'd100) ? 100 : 32'(pct);
  endfunction

  // polarity a, enable a, polarity b, enable b
  function automatic logic [3:0] half_pattern(input logic [2:0] phase);
    case (phase)
      3'd0: return 4'hF;
      3'd1: return 4'hC;
      3'd2: return 4'hA;
      3'd3: return 4'h1;
      3'd4: return 4'h5;
      3'd5: return 4'h6;
      3'd6: return 4'h7;
      default: return 4'hB;
    endcase
  endfunction

  function automatic out_t sine_currents(input int unsigned pct);
    out_t r;
    int unsigned idx, va, vb;
    r = '0;
    idx = (32'(mdl_index) + 32'(cfg_lead)) % 256;
    va = sine_lut[idx];
    vb = sine_lut[(idx + 64) % 256];
    r.polarity_a = (va >= 1600);
    r.polarity_b = (vb >= 1600);
    r.current_a = 11'(((va >= 1600) ? va - 1600 : 1600 - va) * pct / 100);
    r.current_b = 11'(((vb >= 1600) ? vb - 1600 : 1600 - vb) * pct / 100);
    return r;
  endfunction

  function automatic out_t predict_drive(input in_t item);
    out_t r;
    int unsigned sum, moves, amp, on;
    logic [3:0] pat;
    r = '0;
    amp = clip_pct(cfg_amp);
    case (item.cmd)
      CMD_START: begin
        mdl_index = '0;
        mdl_ticks = '0;
        mdl_frac = '0;
        mdl_events = '0;
        mdl_run = 1'b1;
      end
      CMD_STOP: begin
        mdl_run = 1'b0;
        cfg_half = 1'b0;
        r.drive_valid = 1'b1;
      end
      CMD_LOCK: begin
        mdl_run = 1'b0;
        r = sine_currents(clip_pct(item.hold_duty));
        r.drive_valid = 1'b1;
      end
      default: begin
        if (mdl_run) begin
          mdl_ticks = mdl_ticks + 16'd1;
          if (mdl_ticks < cfg_divider) begin
            if (!cfg_half) begin
              r = sine_currents(amp);
              r.drive_valid = 1'b1;
            end
          end else begin
            sum = 32'(mdl_frac) + 32'(cfg_rate);
            moves = sum >> 6;
            mdl_ticks = '0;
            mdl_frac = sum[5:0];
            if (cfg_half) begin
              mdl_half_phase = cfg_reverse ? mdl_half_phase - 3'(moves)
                                           : mdl_half_phase + 3'(moves);
              pat = half_pattern(mdl_half_phase);
              on = amp * 1599 / 100;
              r.current_a = pat[2] ? 11'(on) : 11'd0;
              r.current_b = pat[0] ? 11'(on) : 11'd0;
              r.polarity_a = pat[3];
              r.polarity_b = pat[1];
            end else begin
              mdl_index = cfg_reverse ? mdl_index - 8'(moves) : mdl_index + 8'(moves);
              r = sine_currents(amp);
            end
            r.drive_valid = 1'b1;
            mdl_events = mdl_events + 32'd1;
            mdl_position = cfg_reverse ? mdl_position - 32'd1 : mdl_position + 32'd1;
            // target hit keeps the step polarities but drops the current
            if (cfg_stop_tgt && cfg_target != 0 && mdl_events >= cfg_target) begin
              mdl_run = 1'b0;
              r.current_a = '0;
              r.current_b = '0;
              r.target_reached = 1'b1;
            end
          end
        end
      end
    endcase
    r.running = mdl_run;
    r.position = mdl_position;
    return r;
  endfunction

  task automatic send_cmd(input cmd_e cmd, input logic [6:0] hold);
    in_t item;
    item.cmd = cmd;
    item.hold_duty = hold;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk_i); while (in_stall);
    pending_drives.push_back(predict_drive(item));
  endtask

  // leaves the block idle with every result collected
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_drives.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SPEED_DIVIDER:  cfg_divider = value[15:0];
      REG_STEP_RATE:      cfg_rate = value[8:0];
      REG_AMPLITUDE:      cfg_amp = value[6:0];
      REG_HALF_STEP_MODE: cfg_half = value[0];
      REG_PHASE_LEAD:     cfg_lead = value[6:0];
      REG_REVERSE:        cfg_reverse = value[0];
      REG_STOP_AT_TARGET: cfg_stop_tgt = value[0];
      default:            cfg_target = value;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_all_regs(input logic [31:0] divider, input logic [31:0] rate,
                                input logic [31:0] amp, input logic [31:0] half,
                                input logic [31:0] lead, input logic [31:0] reverse,
                                input logic [31:0] stop_tgt, input logic [31:0] target);
    write_reg(REG_SPEED_DIVIDER, divider);
    write_reg(REG_STEP_RATE, rate);
    write_reg(REG_AMPLITUDE, amp);
    write_reg(REG_HALF_STEP_MODE, half);
    write_reg(REG_PHASE_LEAD, lead);
    write_reg(REG_REVERSE, reverse);
    write_reg(REG_STOP_AT_TARGET, stop_tgt);
    write_reg(REG_TARGET_STEPS, target);
  endtask

  task automatic randomize_config();
    logic [31:0] divider, rate, target;
    case ($urandom_range(9))
      0: divider = 32'd0;
      1: divider = 32'hFFFF;
      2, 3: divider = 32'd1;
      default: divider = $urandom_range(2, 8);
    endcase
    case ($urandom_range(5))
      0: rate = 32'd64;
      1: rate = 32'd256;
      2: rate = 32'd511;
      3: rate = 32'd0;
      default: rate = $urandom_range(511);
    endcase
    case ($urandom_range(4))
      0: target = 32'd0;
      1: target = 32'hFFFF_FFFF;
      2: target = $urandom;
      default: target = $urandom_range(1, 12);
    endcase
    write_all_regs(divider, rate, $urandom_range(127), $urandom_range(1),
                   $urandom_range(127), $urandom_range(1), $urandom_range(1), target);
  endtask

  // mostly start-then-tick runs so the step logic gets exercised
  task automatic run_random(input int count);
    int roll;
    cmd_e cmd;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (!mdl_run) begin
        cmd = (roll < 60) ? CMD_START : cmd_e'($urandom_range(3));
      end else if (roll < 86) begin
        cmd = CMD_TICK;
      end else if (roll < 91) begin
        cmd = CMD_STOP;
      end else if (roll < 96) begin
        cmd = CMD_LOCK;
      end else begin
        cmd = CMD_START;
      end
      send_cmd(cmd, 7'($urandom_range(127)));
    end
  endtask

  task automatic test_basic_commands();
    send_cmd(CMD_TICK, 7'd0);  // stopped drive ignores ticks
    send_cmd(CMD_START, 7'd127);
    repeat (6) send_cmd(CMD_TICK, 7'd0);
    send_cmd(CMD_LOCK, 7'd127);
    send_cmd(CMD_LOCK, 7'd0);
    settle();
  endtask

  task automatic test_extreme_config();
    write_all_regs(32'd0, 32'd511, 32'd127, 32'd1, 32'd127, 32'd1, 32'd1, 32'd3);
    send_cmd(CMD_START, 7'd0);
    repeat (4) send_cmd(CMD_TICK, 7'd64);
    send_cmd(CMD_LOCK, 7'd100);
    send_cmd(CMD_STOP, 7'd127);
    settle();
  endtask

  task automatic test_slow_divider();
    write_all_regs(32'hFFFF, 32'd256, 32'd0, 32'd0, 32'd64, 32'd0, 32'd1, 32'd0);
    send_cmd(CMD_START, 7'd0);
    repeat (4) send_cmd(CMD_TICK, 7'd0);
    send_cmd(CMD_STOP, 7'd0);
    settle();
  endtask

  task automatic test_random_traffic(input int src_pct, input int rcv_pct, input int phases);
    src_idle_pct = src_pct;
    rcv_stall_pct <= rcv_pct;
    for (int p = 0; p < phases; p++) begin
      randomize_config();
      run_random(60);
      settle();
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    rcv_stall_pct <= 0;
    write_all_regs(32'd1, 32'd100, 32'd90, 32'd0, 32'd10, 32'd1, 32'd0, 32'd0);
    stall_hold <= 1'b1;
    fork
      begin
        repeat (HoldoffCycles) @(posedge clk_i);
        stall_hold <= 1'b0;
      end
    join_none
    send_cmd(CMD_START, 7'd0);
    repeat (39) send_cmd(CMD_TICK, 7'($urandom_range(127)));
    settle();
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      drive_errors++;
      if (drive_errors <= 10) begin
        $display("drive mismatch on %s: expected 0x%0h, got 0x%0h", field, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_drives.size() == 0) begin
        drive_errors++;
        if (drive_errors <= 10) begin
          $display("result transaction with nothing pending: position 0x%0h",
                   out_data.position);
        end
      end else begin
        want = pending_drives.pop_front();
        check_field("drive_valid", 32'(want.drive_valid), 32'(out_data.drive_valid));
        check_field("current_a", 32'(want.current_a), 32'(out_data.current_a));
        check_field("current_b", 32'(want.current_b), 32'(out_data.current_b));
        check_field("polarity_a", 32'(want.polarity_a), 32'(out_data.polarity_a));
        check_field("polarity_b", 32'(want.polarity_b), 32'(out_data.polarity_b));
        check_field("running", 32'(want.running), 32'(out_data.running));
        check_field("position", want.position, out_data.position);
        check_field("target_reached", 32'(want.target_reached),
                    32'(out_data.target_reached));
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall <= stall_hold || ($urandom_range(99) < rcv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 256; i++) begin
      sine_lut[i] = int'(1600.0 + 1599.0 * $sin(2.0 * Pi * i / 256.0));
    end
    cfg_divider = 16'd6;
    cfg_rate = 9'd64;
    cfg_amp = 7'd60;
    cfg_half = 1'b0;
    cfg_lead = '0;
    cfg_reverse = 1'b0;
    cfg_stop_tgt = 1'b0;
    cfg_target = '0;
    mdl_run = 1'b0;
    mdl_ticks = '0;
    mdl_frac = '0;
    mdl_index = '0;
    mdl_half_phase = '0;
    mdl_events = '0;
    mdl_position = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_commands();
    test_extreme_config();
    test_slow_divider();
    test_random_traffic(0, 0, 2);
    test_random_traffic(74, 0, 2);
    test_random_traffic(0, 74, 2);
    test_random_traffic(36, 36, 2);
    test_backpressure();

    repeat (20) @(posedge clk_i);
    if (drive_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/smpg_pkg.sv
rtl/smpg_regs.sv
rtl/smpg_ctrl.sv
rtl/smpg_phase.sv
rtl/smpg_current.sv
rtl/stepper_microstep_phase_generator_core.sv
rtl/smpg_checker.sv
tb/stepper_microstep_phase_generator_core_tb.sv
